### hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

### hdl/dis_pkg.sv
package dis_pkg;
  localparam int unsigned MaxRangesDefault = 16;
  localparam int unsigned ValW = 32;

  typedef enum logic [1:0] {
    StStored  = 2'd0,
    StCovered = 2'd1,
    StDropped = 2'd2
  } add_status_e;

  localparam logic ActAdd  = 1'b0;
  localparam logic ActRead = 1'b1;
endpackage

### hdl/dis_ram.sv
module dis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/disjoint_interval_set_unit.sv
// channel | valid    | stall    | payload
// in      | valid_i  | stall_o  | action_i, value_i
// out     | valid_o  | stall_i  | add_status_o, range_low_o, range_high_o, range_valid_o,
//         |          |          | last_item_o
// one item at a time; stall_o stays high while busy or while a beat waits
// an add scans the entries in order through SSrchR and SSrchW, decides in SDec and gives its beat from SOut
// an insert or a join moves one entry at a time, a read state then a write state, through the single read port
// a read emits n beats, one per entry through SRdR and SRdW, held while stalled; an empty table gives one beat
// reset empties the table at once; the entries need no clearing
// a stalled output holds the machine until the beat is taken
`include "assert_macros.svh"
module disjoint_interval_set_unit #(
  parameter int unsigned MAX_RANGES = dis_pkg::MaxRangesDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [0:0]              action_i,
  input  logic signed [dis_pkg::ValW-1:0] value_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [1:0]              add_status_o,
  output logic signed [dis_pkg::ValW-1:0] range_low_o,
  output logic signed [dis_pkg::ValW-1:0] range_high_o,
  output logic                    range_valid_o,
  output logic                    last_item_o
);
  import dis_pkg::*;

  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_RANGES);
  localparam logic signed [ValW:0] ExtOne = (ValW+1)'(1);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SSrchR = 4'd1;
  localparam logic [3:0] SSrchW = 4'd2;
  localparam logic [3:0] SDec   = 4'd3;
  localparam logic [3:0] SInsR  = 4'd4;
  localparam logic [3:0] SInsW  = 4'd5;
  localparam logic [3:0] SJnR   = 4'd6;
  localparam logic [3:0] SJnW   = 4'd7;
  localparam logic [3:0] SOut   = 4'd8;
  localparam logic [3:0] SRdR   = 4'd9;
  localparam logic [3:0] SRdW   = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] p_q, p_d;
  logic [CW-1:0] i_q, i_d;
  logic signed [ValW-1:0] v_q, v_d;
  logic signed [ValW-1:0] loprev_q, loprev_d, hiprev_q, hiprev_d;
  logic signed [ValW-1:0] nlo_q, nlo_d, nhi_q, nhi_d;
  add_status_e st_q, st_d;
  logic ovalid_q, ovalid_d;
  add_status_e ost_q, ost_d;
  logic signed [ValW-1:0] olo_q, olo_d, ohi_q, ohi_d;
  logic orv_q, orv_d, olast_q, olast_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [ValW-1:0] wlo, whi, rlo, rhi;

  dis_ram #(.Width(ValW), .Depth(MAX_RANGES)) u_lo (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wlo), .raddr_i(raddr), .rdata_o(rlo)
  );
  dis_ram #(.Width(ValW), .Depth(MAX_RANGES)) u_hi (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(whi), .raddr_i(raddr), .rdata_o(rhi)
  );

  // adjacency judged one bit wider, so the extremes never touch
  logic signed [ValW:0] v_ext, hp_ext, nlo_ext;
  logic covered, left, right;
  assign v_ext   = {v_q[ValW-1], v_q};
  assign hp_ext  = {hiprev_q[ValW-1], hiprev_q};
  assign nlo_ext = {nlo_q[ValW-1], nlo_q};
  assign covered = (p_q != '0) && (v_q <= hiprev_q);
  assign left    = (p_q != '0) && (hp_ext + ExtOne == v_ext);
  assign right   = (p_q < cnt_q) && (nlo_ext - ExtOne == v_ext);

  assign stall_o = (state_q != SIdle) || ovalid_q;
  assign valid_o = ovalid_q;
  assign add_status_o  = ost_q;
  assign range_low_o   = olo_q;
  assign range_high_o  = ohi_q;
  assign range_valid_o = orv_q;
  assign last_item_o   = olast_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; p_d = p_q; i_d = i_q; v_d = v_q;
    loprev_d = loprev_q; hiprev_d = hiprev_q; nlo_d = nlo_q; nhi_d = nhi_q; st_d = st_q;
    ovalid_d = ovalid_q; ost_d = ost_q; olo_d = olo_q; ohi_d = ohi_q;
    orv_d = orv_q; olast_d = olast_q;
    we = 1'b0; waddr = AW'(i_q); wlo = rlo; whi = rhi; raddr = AW'(i_q);
    if (ovalid_q && !stall_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        if (valid_i && !ovalid_q) begin
          v_d = value_i; p_d = '0; i_d = '0;
          if (action_i[0] == ActAdd) begin
            state_d = SSrchR;
          end else if (cnt_q == '0) begin
            ost_d = StStored; olo_d = '0; ohi_d = '0; orv_d = 1'b0; olast_d = 1'b1;
            ovalid_d = 1'b1;
          end else begin
            state_d = SRdR;
          end
        end
      end
      SSrchR: begin
        state_d = (i_q < cnt_q) ? SSrchW : SDec;
      end
      SSrchW: begin
        if (rlo <= v_q) begin
          loprev_d = rlo; hiprev_d = rhi;
          p_d = i_q + 1'b1; i_d = i_q + 1'b1; state_d = SSrchR;
        end else begin
          nlo_d = rlo; nhi_d = rhi; state_d = SDec;
        end
      end
      SDec: begin
        st_d = StStored; state_d = SOut;
        priority if (covered) begin
          st_d = StCovered;
        end else if (left && right) begin
          we = 1'b1; waddr = AW'(p_q - 1'b1); wlo = loprev_q; whi = nhi_q;
          i_d = p_q; state_d = SJnR;
        end else if (left) begin
          we = 1'b1; waddr = AW'(p_q - 1'b1); wlo = loprev_q; whi = v_q;
        end else if (right) begin
          we = 1'b1; waddr = AW'(p_q); wlo = v_q; whi = nhi_q;
        end else if (cnt_q >= CntMax) begin
          st_d = StDropped;
        end else begin
          i_d = cnt_q; state_d = SInsR;
        end
      end
      SJnR: begin
        if (i_q + 1'b1 < cnt_q) begin
          raddr = AW'(i_q + 1'b1); state_d = SJnW;
        end else begin
          cnt_d = cnt_q - 1'b1; state_d = SOut;
        end
      end
      SJnW: begin
        we = 1'b1; waddr = AW'(i_q); wlo = rlo; whi = rhi;
        i_d = i_q + 1'b1; state_d = SJnR;
      end
      SInsR: begin
        if (i_q > p_q) begin
          raddr = AW'(i_q - 1'b1); state_d = SInsW;
        end else begin
          we = 1'b1; waddr = AW'(p_q); wlo = v_q; whi = v_q;
          cnt_d = cnt_q + 1'b1; state_d = SOut;
        end
      end
      SInsW: begin
        we = 1'b1; waddr = AW'(i_q); wlo = rlo; whi = rhi;
        i_d = i_q - 1'b1; state_d = SInsR;
      end
      SOut: begin
        if (!ovalid_q || !stall_i) begin
          ost_d = st_q; olo_d = '0; ohi_d = '0; orv_d = 1'b0; olast_d = 1'b1;
          ovalid_d = 1'b1; state_d = SIdle;
        end
      end
      SRdR: begin
        state_d = SRdW;
      end
      SRdW: begin
        if (!ovalid_q || !stall_i) begin
          ost_d = StStored; olo_d = rlo; ohi_d = rhi; orv_d = 1'b1;
          olast_d = (i_q + 1'b1 == cnt_q);
          ovalid_d = 1'b1; i_d = i_q + 1'b1;
          state_d = (i_q + 1'b1 == cnt_q) ? SIdle : SRdR;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= '0; p_q <= '0; i_q <= '0; v_q <= '0;
      loprev_q <= '0; hiprev_q <= '0; nlo_q <= '0; nhi_q <= '0; st_q <= StStored;
      ovalid_q <= 1'b0; ost_q <= StStored; olo_q <= '0; ohi_q <= '0;
      orv_q <= 1'b0; olast_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; p_q <= p_d; i_q <= i_d; v_q <= v_d;
      loprev_q <= loprev_d; hiprev_q <= hiprev_d; nlo_q <= nlo_d; nhi_q <= nhi_d;
      st_q <= st_d;
      ovalid_q <= ovalid_d; ost_q <= ost_d; olo_q <= olo_d; ohi_q <= ohi_d;
      orv_q <= orv_d; olast_q <= olast_d;
    end
  end

  `ASSERT_CLK(a_cnt_max, clk_i, rst_ni, cnt_q <= CntMax, "range count above table depth")
  `ASSERT_CLK(a_busy_stall, clk_i, rst_ni, (state_q != SIdle) |-> stall_o, "busy without stall")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (valid_o && stall_i) |=> valid_o, "beat lost")
  `ASSERT_CLK(a_out_low, clk_i, rst_ni, (valid_o && stall_i) |=> $stable(range_low_o), "beat changed")
  `ASSERT_NEVER(a_busy_accept, clk_i, rst_ni, valid_i && !stall_o && state_q != SIdle, "accept while busy")
endmodule
